// ===== hdl/idq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_pkg: shared types and codes for the indexed double-ended queue
// Request and response payloads, action codes and status codes.
// ----------------------------------------------------------------------------
package idq_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 9;

  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_POP_BACK   = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_READ       = 3'd4;
  localparam logic [2:0] ACT_WRITE      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]               action;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       count;
  } rsp_t;

  // Result of one action, minus the word that comes back from the store.
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       count;
    logic                     use_rd;
  } rsp_meta_t;

endpackage

// ===== hdl/idq_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_store: word storage of the queue
// Single-port memory: one shared address per cycle, for a write, a registered read or both.
// ----------------------------------------------------------------------------
module idq_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic                                re,
  input  logic [AW-1:0]                       addr,
  input  logic signed [idq_pkg::DATA_W-1:0]   wdata,
  output logic signed [idq_pkg::DATA_W-1:0]   rdata
);

  logic signed [idq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/idq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_ctrl: pointer and bounds control
// Holds head, fill and low bound, decodes one request per cycle while fire is
// high into a store access and the response status.
// ----------------------------------------------------------------------------
module idq_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int FW    = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  idq_pkg::req_t                     req,
  output idq_pkg::rsp_meta_t                meta,
  output logic                              mem_we,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_addr,
  output logic signed [idq_pkg::DATA_W-1:0] mem_wdata
);

  logic [AW-1:0]              head, head_next;
  logic [FW-1:0]              fill, fill_next;
  logic [idq_pkg::DATA_W-1:0] low_bound, low_bound_next;
  logic [idq_pkg::DATA_W-1:0] off;
  logic                       in_range, is_full, is_empty;
  logic [AW-1:0]              rel, slot, head_inc;
  logic                       we, re;
  logic [1:0]                 status;
  logic signed [idq_pkg::DATA_W-1:0] data;

  // head + offset is below 2*DEPTH, so one compare and subtract wraps it
  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] d;
    d = s - (AW+1)'(DEPTH);
    return (s >= (AW+1)'(DEPTH)) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  assign is_full  = (fill == FW'(DEPTH));
  assign is_empty = (fill == '0);
  assign off      = $unsigned(req.index) - low_bound;
  assign in_range = (off < idq_pkg::DATA_W'(fill));
  assign slot     = wrap({1'b0, head} + {1'b0, rel});
  assign head_inc = wrap({1'b0, head} + (AW+1)'(1));

  always_comb begin
    rel            = '0;
    we             = 1'b0;
    re             = 1'b0;
    status         = idq_pkg::ST_OK;
    data           = '0;
    head_next      = head;
    fill_next      = fill;
    low_bound_next = low_bound;
    case (req.action)
      idq_pkg::ACT_PUSH_BACK: begin
        rel = AW'(fill);
        if (is_full) begin
          status = idq_pkg::ST_FULL;
        end else begin
          we        = 1'b1;
          fill_next = fill + 1'b1;
        end
      end
      idq_pkg::ACT_PUSH_FRONT: begin
        rel = AW'(DEPTH - 1);
        if (is_full) begin
          status = idq_pkg::ST_FULL;
        end else begin
          we             = 1'b1;
          head_next      = slot;
          fill_next      = fill + 1'b1;
          low_bound_next = low_bound - 1'b1;
        end
      end
      idq_pkg::ACT_POP_BACK: begin
        rel = AW'(fill - 1'b1);
        if (is_empty) begin
          status = idq_pkg::ST_EMPTY;
        end else begin
          re        = 1'b1;
          fill_next = fill - 1'b1;
        end
      end
      idq_pkg::ACT_POP_FRONT: begin
        if (is_empty) begin
          status = idq_pkg::ST_EMPTY;
        end else begin
          re             = 1'b1;
          head_next      = head_inc;
          fill_next      = fill - 1'b1;
          low_bound_next = low_bound + 1'b1;
        end
      end
      idq_pkg::ACT_READ: begin
        rel = AW'(off);
        if (!in_range) begin
          status = idq_pkg::ST_RANGE;
        end else begin
          re = 1'b1;
        end
      end
      idq_pkg::ACT_WRITE: begin
        rel = AW'(off);
        if (!in_range) begin
          status = idq_pkg::ST_RANGE;
        end else begin
          we   = 1'b1;
          data = req.value;
        end
      end
      default: begin
        // unused codes: no change, current count
      end
    endcase
  end

  assign mem_we    = fire & we;
  assign mem_re    = fire & re;
  assign mem_addr  = slot;
  assign mem_wdata = req.value;

  assign meta.data   = data;
  assign meta.status = status;
  assign meta.count  = idq_pkg::COUNT_W'(fill_next);
  assign meta.use_rd = re;

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      fill      <= '0;
      low_bound <= '0;
    end else if (fire) begin
      head      <= head_next;
      fill      <= fill_next;
      low_bound <= low_bound_next;
    end
  end

endmodule

// ===== hdl/indexed_double_ended_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_double_ended_queue_top: indexed double-ended queue
// Circular-buffer deque of signed words with push/pop at both ends and
// bounds-checked indexed read and write.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | idq_pkg::req_t
//  rsp     | out       | rsp_valid / rsp_ready | idq_pkg::rsp_t
//
//  Response path: the request sits in the
//  input register, then one pass through the pointer logic and the single
//  store port loads the output stage.
//  One request per cycle sustained while rsp_ready stays high; the single store port sets that figure.
//  Reset clears head, fill and low bound; no clearing pass.
//  A stalled response holds the output stage and any request waiting in the
//  input register; the request side stalls only when both are full.
// ----------------------------------------------------------------------------
module indexed_double_ended_queue_top #(
  parameter int DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  idq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output idq_pkg::rsp_t rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic               s0_valid;
  idq_pkg::req_t      s0_req;
  logic               s1_valid;
  idq_pkg::rsp_meta_t s1_meta;
  idq_pkg::rsp_meta_t meta;
  logic               fire, s1_free;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_addr;
  logic signed [idq_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

  assign s1_free   = !s1_valid || rsp_ready;
  assign fire      = s0_valid && s1_free;
  assign req_ready = !s0_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (req_ready) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s0_req <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_meta <= meta;
    end
  end

  idq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .FW    (FW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req       (s0_req),
    .meta      (meta),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata)
  );

  idq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // read data is only refreshed on fire, so it holds while stalled
  assign rsp_valid  = s1_valid;
  assign rsp.data   = s1_meta.use_rd ? mem_rdata : s1_meta.data;
  assign rsp.status = s1_meta.status;
  assign rsp.count  = s1_meta.count;

endmodule

// ===== hdl/idq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_checker: port-level checks for the indexed double-ended queue
// Watches the response channel; bound to the top level below.
// ----------------------------------------------------------------------------
module idq_checker #(
  parameter int DEPTH = 256
) (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input idq_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != idq_pkg::ST_OK |-> rsp.data == '0)
    else $error("error response with nonzero data");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == idq_pkg::ST_EMPTY |-> rsp.count == '0)
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == idq_pkg::ST_FULL |->
      rsp.count == idq_pkg::COUNT_W'(DEPTH))
    else $error("full status with wrong count");

  // after reset a request must pass the input register and the output stage before any response comes out
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response right after reset");

endmodule

bind indexed_double_ended_queue_top idq_checker #(.DEPTH(DEPTH)) u_idq_checker (.*);
